/* hdl/l2q_pkg.sv */
// Shared types and constants for the log2 sample quantiser.
// No dependencies.
`default_nettype none
package l2q_pkg;

    localparam int unsigned MANT_W = 63;
    localparam int unsigned EXP_W  = 11;
    localparam int unsigned CODE_W = 16;
    localparam int unsigned STAT_W = 2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_LOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_HIGH = 2'd2;
    localparam logic [STAT_W-1:0] ST_NAN  = 2'd3;

    localparam logic [6:0] LOG_SCALE = 7'd100;
    localparam logic [CODE_W-1:0] CODE_MAX = 16'hFFFF;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [EXP_W-1:0]  expo;
        logic              last;
    } side_t;

endpackage
`default_nettype wire

/* hdl/log2_sample_quantizer.sv */
// Log2 sample quantiser: one decode stage, a chain of squaring cells (two stages each)
// and a clamping output stage. Depends on l2q_pkg, l2q_decode, l2q_cell, l2q_finish.
//
// Takes one IEEE float32 or float64 word per cycle while sample_stall is low and returns
// floor(100*log2(x)) as a 16-bit code with a status (ok, clamped low, clamped high, not a
// number). Each word passes through the decode stage, the chain of squaring cells, each of
// which squares the mantissa over two stages and yields one fraction bit, and the output
// stage. Throughput is one word per cycle while sample_stall is low; a one-word input
// skid holds a word taken while the output stalls. Write sample_format only while the
// block is empty.
`default_nettype none
module log2_sample_quantizer #(
    parameter int unsigned LOG_FRACTION_BITS = 40
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           sample_format,
    input  wire logic                           sample_valid,
    output logic                                sample_stall,
    input  wire logic [63:0]                    sample_bits,
    input  wire logic                           is_last,
    output logic                                code_valid,
    input  wire logic                           code_stall,
    output logic [l2q_pkg::CODE_W-1:0]          code,
    output logic [l2q_pkg::STAT_W-1:0]          status,
    output logic                                last_out
);

    localparam int unsigned F = LOG_FRACTION_BITS;

    logic        fmt_reg;
    logic        skid_valid_reg;
    logic [63:0] skid_bits_reg;
    logic        skid_last_reg;
    logic        adv;
    logic        take;
    logic        load;
    logic [63:0] load_bits;
    logic        load_last;

    logic                          cv [0:F];
    l2q_pkg::side_t                cs [0:F];
    logic [l2q_pkg::MANT_W-1:0]    cy [0:F];
    logic [F-1:0]                  cf [0:F];

    assign cfg_ready    = 1'b1;
    assign adv          = !code_valid || !code_stall;
    assign sample_stall = skid_valid_reg;
    assign take         = sample_valid && !skid_valid_reg;
    assign load         = skid_valid_reg || take;
    assign load_bits    = skid_valid_reg ? skid_bits_reg : sample_bits;
    assign load_last    = skid_valid_reg ? skid_last_reg : is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg        <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                fmt_reg <= sample_format;
            if (adv)
                skid_valid_reg <= 1'b0;
            else if (take)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!adv && take)
        begin
            skid_bits_reg <= sample_bits;
            skid_last_reg <= is_last;
        end
    end

    l2q_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .load  (load),
        .fmt   (fmt_reg),
        .bits  (load_bits),
        .last  (load_last),
        .valid (cv[0]),
        .side  (cs[0]),
        .y     (cy[0])
    );

    assign cf[0] = '0;

    for (genvar i = 0; i < F; i++)
    begin : g_cell
        l2q_cell #(
            .FRAC_W (F)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (cv[i]),
            .in_side   (cs[i]),
            .in_y      (cy[i]),
            .in_frac   (cf[i]),
            .out_valid (cv[i+1]),
            .out_side  (cs[i+1]),
            .out_y     (cy[i+1]),
            .out_frac  (cf[i+1])
        );
    end

    l2q_finish #(
        .FRAC_W (F)
    ) u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (cv[F]),
        .in_side  (cs[F]),
        .in_frac  (cf[F]),
        .valid    (code_valid),
        .code     (code),
        .status   (status),
        .last     (last_out)
    );

`ifndef SYNTHESIS
    a_nan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && status == l2q_pkg::ST_NAN |-> code == '0)
        else $error("NaN result with non-zero code");
    a_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && status == l2q_pkg::ST_LOW |-> code == '0)
        else $error("clamped-low result with non-zero code");
    a_high_max: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && status == l2q_pkg::ST_HIGH |-> code == l2q_pkg::CODE_MAX)
        else $error("clamped-high result not at full scale");
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_stall) |-> $past(code_valid && code_stall))
        else $error("input skid filled without an output stall");
`endif

endmodule
`default_nettype wire

/* hdl/l2q_decode.sv */
// Front stage: splits a raw float32/float64 word into class, exponent and Q1.62 mantissa.
// Depends on l2q_pkg.
`default_nettype none
module l2q_decode (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           adv,
    input  wire logic                           load,
    input  wire logic                           fmt,
    input  wire logic [63:0]                    bits,
    input  wire logic                           last,
    output logic                                valid,
    output l2q_pkg::side_t                      side,
    output logic [l2q_pkg::MANT_W-1:0]          y
);

    logic                          valid_reg;
    l2q_pkg::side_t                side_reg, side_next;
    logic [l2q_pkg::MANT_W-1:0]    y_reg, y_next;

    logic        sgn;
    logic [10:0] ex;
    logic [10:0] bias;
    logic        ex_max;
    logic        mant_nz;

    always_comb
    begin
        if (fmt)
        begin
            sgn     = bits[63];
            ex      = bits[62:52];
            bias    = 11'd1023;
            ex_max  = (bits[62:52] == 11'h7FF);
            mant_nz = (bits[51:0] != 52'd0);
            y_next  = {1'b1, bits[51:0], 10'd0};
        end
        else
        begin
            sgn     = bits[31];
            ex      = {3'd0, bits[30:23]};
            bias    = 11'd127;
            ex_max  = (bits[30:23] == 8'hFF);
            mant_nz = (bits[22:0] != 23'd0);
            y_next  = {1'b1, bits[22:0], 39'd0};
        end
        side_next.last = last;
        side_next.expo = ex - bias;
        if (ex_max && mant_nz)
            side_next.status = l2q_pkg::ST_NAN;
        else if (sgn)
            side_next.status = l2q_pkg::ST_LOW;
        else if (ex_max)
            side_next.status = l2q_pkg::ST_HIGH;
        else if (ex < bias)
            side_next.status = l2q_pkg::ST_LOW;
        else
            side_next.status = l2q_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg <= side_next;
            y_reg    <= y_next;
        end
    end

    assign valid = valid_reg;
    assign side  = side_reg;
    assign y     = y_reg;

endmodule
`default_nettype wire

/* hdl/l2q_cell.sv */
// One squaring cell: squares the Q1.62 mantissa over two stages and yields one log2 fraction bit.
// Depends on l2q_pkg.
`default_nettype none
module l2q_cell #(
    parameter int unsigned FRAC_W = 40
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           adv,
    input  wire logic                           in_valid,
    input  wire l2q_pkg::side_t                 in_side,
    input  wire logic [l2q_pkg::MANT_W-1:0]     in_y,
    input  wire logic [FRAC_W-1:0]              in_frac,
    output logic                                out_valid,
    output l2q_pkg::side_t                      out_side,
    output logic [l2q_pkg::MANT_W-1:0]          out_y,
    output logic [FRAC_W-1:0]                   out_frac
);

    logic                          v1_reg, v2_reg;
    l2q_pkg::side_t                s1_reg, s2_reg;
    logic [FRAC_W-1:0]             f1_reg, f2_reg, f2_next;
    logic [61:0]                   hh_reg;
    logic [62:0]                   hl_reg;
    logic [63:0]                   ll_reg;
    logic [l2q_pkg::MANT_W-1:0]    y2_reg, y2_next;

    logic [30:0]  ah;
    logic [31:0]  al;
    logic [125:0] sq;
    logic [63:0]  r;

    assign ah = in_y[62:32];
    assign al = in_y[31:0];

    always_comb
    begin
        sq = {hh_reg, 64'd0} + {30'd0, hl_reg, 33'd0} + {62'd0, ll_reg};
        r  = sq[125:62];
        if (r[63])
        begin
            y2_next = r[63:1];
            f2_next = {f1_reg[FRAC_W-2:0], 1'b1};
        end
        else
        begin
            y2_next = r[62:0];
            f2_next = {f1_reg[FRAC_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hh_reg <= {31'd0, ah} * {31'd0, ah};
            hl_reg <= {32'd0, ah} * {31'd0, al};
            ll_reg <= {32'd0, al} * {32'd0, al};
            s1_reg <= in_side;
            f1_reg <= in_frac;
            s2_reg <= s1_reg;
            f2_reg <= f2_next;
            y2_reg <= y2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_side  = s2_reg;
    assign out_y     = y2_reg;
    assign out_frac  = f2_reg;

endmodule
`default_nettype wire

/* hdl/l2q_finish.sv */
// Output stage: scales the log2 fraction by 100, adds the exponent term and clamps.
// Depends on l2q_pkg.
`default_nettype none
module l2q_finish #(
    parameter int unsigned FRAC_W = 40
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           adv,
    input  wire logic                           in_valid,
    input  wire l2q_pkg::side_t                 in_side,
    input  wire logic [FRAC_W-1:0]              in_frac,
    output logic                                valid,
    output logic [l2q_pkg::CODE_W-1:0]          code,
    output logic [l2q_pkg::STAT_W-1:0]          status,
    output logic                                last
);

    logic                           valid_reg;
    logic [l2q_pkg::CODE_W-1:0]     code_reg, code_next;
    logic [l2q_pkg::STAT_W-1:0]     status_reg, status_next;
    logic                           last_reg;

    logic [FRAC_W+6:0] prod;
    logic [6:0]        fine;
    logic [17:0]       v;

    always_comb
    begin
        prod = {7'd0, in_frac} * (FRAC_W+7)'(l2q_pkg::LOG_SCALE);
        fine = prod[FRAC_W+6:FRAC_W];
        v    = {7'd0, in_side.expo} * {11'd0, l2q_pkg::LOG_SCALE} + {11'd0, fine};
        code_next   = '0;
        status_next = in_side.status;
        case (in_side.status)
            l2q_pkg::ST_HIGH: code_next = l2q_pkg::CODE_MAX;
            l2q_pkg::ST_OK:
            begin
                if (v[17:16] != 2'd0)
                begin
                    code_next   = l2q_pkg::CODE_MAX;
                    status_next = l2q_pkg::ST_HIGH;
                end
                else
                    code_next = v[15:0];
            end
            default: code_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            code_reg   <= code_next;
            status_reg <= status_next;
            last_reg   <= in_side.last;
        end
    end

    assign valid  = valid_reg;
    assign code   = code_reg;
    assign status = status_reg;
    assign last   = last_reg;

endmodule
`default_nettype wire
